// ===== rtl/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned WEIGHT_W    = FRAC_W + 1;
  localparam int unsigned ENTRY_W     = 2 * VALUE_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_FIRST = 2'd1;
  localparam logic [1:0] CLAMP_LAST  = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] ordinate;
    logic signed [VALUE_W-1:0] abscissa;
  } tli_entry_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [VALUE_W-1:0] divisor;
  } tli_div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quotient;
  } tli_div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_GET_I,
    S_GET_I1,
    S_GET_IM1,
    S_GET_I2,
    S_DECIDE,
    S_SRCH_LOOP,
    S_SRCH_MID,
    S_SRCH_CMP,
    S_SRCH_HIGH,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_WEIGHT,
    S_DIV,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_OUT
  } tli_state_e;

endpackage

// ===== rtl/tli_ram.sv =====
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/tli_divider.sv =====
// ----------------------------------------------------------------------------
// tli_divider
// Restoring divider for the interval weight, one quotient bit per cycle.
// Expects 0 < dividend < divisor; gives floor(dividend * 2^FRAC_W / divisor).
// ----------------------------------------------------------------------------
module tli_divider
  import tli_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tli_div_req_t req_i,
  output tli_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(FRAC_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W-1:0] dvs_q, dvs_d;
  logic [FRAC_W-1:0]  quo_q, quo_d;
  logic [VALUE_W:0]   rem2;
  logic [VALUE_W:0]   diff;
  logic               take;

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, dvs_q};
  assign take = (rem2 >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = take ? diff[VALUE_W-1:0] : rem2[VALUE_W-1:0];
      quo_d = {quo_q[FRAC_W-2:0], take};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(FRAC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// Query path: a query is clamped to the first entry, else clamped to the last,
// else interpolated, through the divider when the point lies strictly inside
// its interval; each binary search probe uses the single table read port.
// Throughput: loads back to back; a query holds off input until its result is
// registered, after which the next transaction can be taken.
// Reset: entry count 1, cached interval 0, table undefined until loaded.
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise-linear Q16.16 table lookup with a cached interval, binary search
// fallback, iterative weight divider and a shared multiplier.
// ----------------------------------------------------------------------------
module table_linear_interpolator
  import tli_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [COUNT_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [INDEX_W-1:0]        entry_index_i,
  input  logic signed [VALUE_W-1:0] entry_abscissa_i,
  input  logic signed [VALUE_W-1:0] entry_ordinate_i,
  input  logic signed [VALUE_W-1:0] query_x_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] result_value_o,
  output logic [INDEX_W-1:0]        interval_found_o,
  output logic [1:0]                clamp_kind_o
);

  localparam int unsigned PROD_W = VALUE_W + WEIGHT_W + 1;

  tli_state_e state_q, state_d;

  logic [COUNT_W-1:0]        entries_q;
  logic [COUNT_W-1:0]        n_q, n_d, n_eff, nm1, nm2;
  logic [INDEX_W-1:0]        cache_q, cache_d;
  logic signed [VALUE_W-1:0] x_q, x_d;
  logic signed [VALUE_W-1:0] ai_q, ai_d, ai1_q, ai1_d, aim1_q, aim1_d, ai2_q, ai2_d;
  logic signed [VALUE_W-1:0] amid_q, amid_d;
  logic [INDEX_W-1:0]        low_q, low_d, high_q, high_d, mid_q, mid_d, i_q, i_d;
  logic signed [VALUE_W-1:0] a0_q, a0_d, f0_q, f0_d, f1_q, f1_d;
  logic signed [VALUE_W:0]   d_q, d_d, r_q, r_d;
  logic [WEIGHT_W-1:0]       p0_q, p0_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d, acc_q, acc_d, sum;
  logic signed [VALUE_W-1:0] y_q, y_d;
  logic [INDEX_W-1:0]        widx_q, widx_d;
  logic [1:0]                wkind_q, wkind_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic [INDEX_W-1:0]        out_idx_q, out_idx_d;
  logic [1:0]                out_kind_q, out_kind_d;

  logic                      in_acc, ram_we, out_free;
  logic [INDEX_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]        ram_rdata;
  tli_entry_t                rd_entry, wr_entry;
  logic signed [VALUE_W-1:0] rd_abs, rd_ord;
  tli_div_req_t              div_req;
  tli_div_rsp_t              div_rsp;

  logic                      first_clamp, last_clamp, stale, has_lo, has_hi;
  logic                      go_lo, go_hi, miss, span_big;
  logic [INDEX_W:0]          mid_sum;
  logic signed [VALUE_W-1:0] mul_a;
  logic signed [WEIGHT_W:0]  mul_b;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ram_we     = in_acc && (mode_i == MODE_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign wr_entry.abscissa = entry_abscissa_i;
  assign wr_entry.ordinate = entry_ordinate_i;
  assign rd_entry = tli_entry_t'(ram_rdata);
  assign rd_abs   = rd_entry.abscissa;
  assign rd_ord   = rd_entry.ordinate;

  tli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i),
    .wdata_i (ENTRY_W'(wr_entry)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tli_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (entries_q == '0) begin
      n_eff = COUNT_W'(1);
    end else if (entries_q > COUNT_W'(TABLE_DEPTH)) begin
      n_eff = COUNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = entries_q;
    end
  end

  assign nm1         = n_q - COUNT_W'(1);
  assign nm2         = n_q - COUNT_W'(2);
  assign first_clamp = (n_q == COUNT_W'(1)) || (x_q <= rd_abs);
  assign last_clamp  = (x_q >= rd_abs);
  assign stale       = ({1'b0, cache_q} > nm2);
  assign has_lo      = (cache_q != '0);
  assign has_hi      = ({1'b0, cache_q} < nm2);
  assign go_lo       = has_lo && (aim1_q <= x_q) && (x_q < ai_q);
  assign go_hi       = has_hi && (ai1_q <= x_q) && (x_q <= ai2_q);
  assign miss        = (x_q < ai_q) || (x_q > ai1_q);
  assign span_big    = ((high_q - low_q) > INDEX_W'(1));
  assign mid_sum     = {1'b0, low_q} + {1'b0, high_q};
  assign sum         = acc_q + prod_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_acc && (mode_i == MODE_QUERY)) state_d = S_CHK_FIRST;
      S_CHK_FIRST: state_d = first_clamp ? S_OUT : S_CHK_LAST;
      S_CHK_LAST: begin
        if (last_clamp) begin
          state_d = S_OUT;
        end else if (stale) begin
          state_d = S_SRCH_LOOP;
        end else begin
          state_d = S_GET_I;
        end
      end
      S_GET_I:     state_d = S_GET_I1;
      S_GET_I1: begin
        if (has_lo) begin
          state_d = S_GET_IM1;
        end else if (has_hi) begin
          state_d = S_GET_I2;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_GET_IM1:   state_d = has_hi ? S_GET_I2 : S_DECIDE;
      S_GET_I2:    state_d = S_DECIDE;
      S_DECIDE: begin
        if (!go_lo && !go_hi && miss) begin
          state_d = S_SRCH_LOOP;
        end else begin
          state_d = S_FETCH0;
        end
      end
      S_SRCH_LOOP: begin
        if (span_big) begin
          state_d = S_SRCH_MID;
        end else if (low_q < high_q) begin
          state_d = S_SRCH_HIGH;
        end else begin
          state_d = S_FETCH0;
        end
      end
      S_SRCH_MID:  state_d = S_SRCH_CMP;
      S_SRCH_CMP:  state_d = S_SRCH_LOOP;
      S_SRCH_HIGH: state_d = S_FETCH0;
      S_FETCH0:    state_d = S_FETCH1;
      S_FETCH1:    state_d = S_FETCH2;
      S_FETCH2:    state_d = S_WEIGHT;
      S_WEIGHT: begin
        if (d_q <= 0) begin
          state_d = S_OUT;
        end else if ((r_q <= 0) || (r_q >= d_q)) begin
          state_d = S_MUL0;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:       if (div_rsp.done) state_d = S_MUL0;
      S_MUL0:      state_d = S_MUL1;
      S_MUL1:      state_d = S_MUL2;
      S_MUL2:      state_d = S_OUT;
      S_OUT:       if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // table read address and divider start
  always_comb begin
    ram_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = r_q[VALUE_W-1:0];
    div_req.divisor  = d_q[VALUE_W-1:0];
    case (state_q)
      S_CHK_FIRST: ram_raddr = nm1[INDEX_W-1:0];
      S_CHK_LAST:  ram_raddr = cache_q;
      S_GET_I:     ram_raddr = cache_q + INDEX_W'(1);
      S_GET_I1:    ram_raddr = has_lo ? (cache_q - INDEX_W'(1)) : (cache_q + INDEX_W'(2));
      S_GET_IM1:   ram_raddr = cache_q + INDEX_W'(2);
      S_SRCH_LOOP: ram_raddr = span_big ? mid_sum[INDEX_W:1] : high_q;
      S_SRCH_MID:  ram_raddr = mid_q + INDEX_W'(1);
      S_FETCH0:    ram_raddr = i_q;
      S_FETCH1:    ram_raddr = i_q + INDEX_W'(1);
      S_WEIGHT:    div_req.start = (d_q > 0) && (r_q > 0) && (r_q < d_q);
      default:     ram_raddr = '0;
    endcase
  end

  always_comb begin
    mul_a = f0_q;
    mul_b = $signed({1'b0, p0_q});
    if (state_q == S_MUL1) begin
      mul_a = f1_q;
      mul_b = $signed({1'b0, WEIGHT_ONE - p0_q});
    end
  end

  // datapath
  always_comb begin
    n_d     = n_q;
    cache_d = cache_q;
    x_d     = x_q;
    ai_d    = ai_q;
    ai1_d   = ai1_q;
    aim1_d  = aim1_q;
    ai2_d   = ai2_q;
    amid_d  = amid_q;
    low_d   = low_q;
    high_d  = high_q;
    mid_d   = mid_q;
    i_d     = i_q;
    a0_d    = a0_q;
    f0_d    = f0_q;
    f1_d    = f1_q;
    d_d     = d_q;
    r_d     = r_q;
    p0_d    = p0_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    y_d     = y_q;
    widx_d  = widx_q;
    wkind_d = wkind_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_idx_d   = out_idx_q;
    out_kind_d  = out_kind_q;
    case (state_q)
      S_IDLE: begin
        x_d = query_x_i;
        n_d = n_eff;
      end
      S_CHK_FIRST: begin
        y_d     = rd_ord;
        widx_d  = '0;
        wkind_d = CLAMP_FIRST;
      end
      S_CHK_LAST: begin
        y_d     = rd_ord;
        widx_d  = '0;
        wkind_d = CLAMP_LAST;
        low_d   = '0;
        high_d  = nm2[INDEX_W-1:0];
      end
      S_GET_I:   ai_d   = rd_abs;
      S_GET_I1:  ai1_d  = rd_abs;
      S_GET_IM1: aim1_d = rd_abs;
      S_GET_I2:  ai2_d  = rd_abs;
      S_DECIDE: begin
        low_d  = '0;
        high_d = nm2[INDEX_W-1:0];
        if (go_lo) begin
          i_d = cache_q - INDEX_W'(1);
        end else if (go_hi) begin
          i_d = cache_q + INDEX_W'(1);
        end else begin
          i_d = cache_q;
        end
      end
      S_SRCH_LOOP: begin
        mid_d = mid_sum[INDEX_W:1];
        i_d   = low_q;
      end
      S_SRCH_MID: amid_d = rd_abs;
      S_SRCH_CMP: begin
        if (x_q < amid_q) begin
          high_d = mid_q;
        end else if (x_q > rd_abs) begin
          low_d = mid_q;
        end else begin
          low_d  = mid_q;
          high_d = mid_q;
        end
      end
      S_SRCH_HIGH: i_d = (rd_abs <= x_q) ? high_q : low_q;
      S_FETCH1: begin
        a0_d = rd_abs;
        f0_d = rd_ord;
      end
      S_FETCH2: begin
        f1_d    = rd_ord;
        d_d     = $signed({rd_abs[VALUE_W-1], rd_abs}) - $signed({a0_q[VALUE_W-1], a0_q});
        r_d     = $signed({rd_abs[VALUE_W-1], rd_abs}) - $signed({x_q[VALUE_W-1], x_q});
        cache_d = i_q;
        widx_d  = i_q;
        wkind_d = CLAMP_NONE;
      end
      S_WEIGHT: begin
        y_d = f0_q;
        if (r_q <= 0) begin
          p0_d = '0;
        end else begin
          p0_d = WEIGHT_ONE;
        end
      end
      S_DIV: p0_d = {1'b0, div_rsp.quotient};
      S_MUL0: prod_d = mul_a * mul_b;
      S_MUL1: begin
        acc_d  = prod_q;
        prod_d = mul_a * mul_b;
      end
      S_MUL2: y_d = sum[FRAC_W+VALUE_W-1:FRAC_W];
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = y_q;
          out_idx_d   = widx_q;
          out_kind_d  = wkind_q;
        end
      end
      default: begin
        y_d = y_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= COUNT_W'(1);
      cache_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cache_q     <= cache_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        entries_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    x_q         <= x_d;
    ai_q        <= ai_d;
    ai1_q       <= ai1_d;
    aim1_q      <= aim1_d;
    ai2_q       <= ai2_d;
    amid_q      <= amid_d;
    low_q       <= low_d;
    high_q      <= high_d;
    mid_q       <= mid_d;
    i_q         <= i_d;
    a0_q        <= a0_d;
    f0_q        <= f0_d;
    f1_q        <= f1_d;
    d_q         <= d_d;
    r_q         <= r_d;
    p0_q        <= p0_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    y_q         <= y_d;
    widx_q      <= widx_d;
    wkind_q     <= wkind_d;
    out_value_q <= out_value_d;
    out_idx_q   <= out_idx_d;
    out_kind_q  <= out_kind_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = out_value_q;
  assign interval_found_o = out_idx_q;
  assign clamp_kind_o     = out_kind_q;

  a_cache_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cache_q <= INDEX_W'(TABLE_DEPTH - 2))
    else $error("cached interval beyond last interval");

  a_clamp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q != CLAMP_NONE) |-> (out_idx_q == '0))
    else $error("clamped transaction reports nonzero interval");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished outside of its wait state");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_LOOP) |-> (low_q <= high_q))
    else $error("binary search bounds crossed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_value_q))
    else $error("stalled result changed");

endmodule
